// File: rtl/core/rbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_pkg - shared types and constants of the ROM/RAM bank mapper
// Address map, result target codes, register indexes and the structs
// passed between the mapper's submodules.
// ----------------------------------------------------------------------------
package rbm_pkg;

	// Default number of cartridge RAM banks of 8 KiB each.
	localparam int RAM_BANKS_DEF = 4;
	// Largest ROM bank count; the bank count saturates here and the bank mask is the bank count minus one.
	localparam int ROM_BANKS_MAX = 32;

	localparam int ADDR_W      = 16;
	localparam int DATA_W      = 8;
	localparam int ROM_ADDR_W  = 19;
	localparam int ROM_BANK_W  = 5;
	localparam int RAM_BANK_W  = 2;
	localparam int RAM_OFF_W   = 13;
	localparam int RAM_IDX_W   = RAM_BANK_W + RAM_OFF_W;
	localparam int ROM_OFF_W   = 14;
	localparam int SIZE_CODE_W = 3;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	// Bus address map.
	localparam logic [ADDR_W-1:0] RAM_EN_END   = 16'h1FFF;
	localparam logic [ADDR_W-1:0] ROM_BANK_END = 16'h3FFF;
	localparam logic [ADDR_W-1:0] RAM_BANK_END = 16'h5FFF;
	localparam logic [ADDR_W-1:0] ROM_AREA_END = 16'h7FFF;
	localparam logic [ADDR_W-1:0] ROM_BANK1_LO = 16'h4000;
	localparam logic [ADDR_W-1:0] RAM_AREA_LO  = 16'hA000;
	localparam logic [ADDR_W-1:0] RAM_AREA_HI  = 16'hBFFF;

	localparam logic [3:0]        RAM_EN_KEY  = 4'hA;
	localparam logic [DATA_W-1:0] OPEN_BUS    = 8'hFF;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_ROM  = 2'd1,
		TGT_RAM  = 2'd2
	} target_t;

	typedef enum logic {
		MODE_READ  = 1'b0,
		MODE_WRITE = 1'b1
	} mode_t;

	typedef enum logic {
		REG_ROM_SIZE = 1'b0,
		REG_RAM_MASK = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [SIZE_CODE_W-1:0] rom_size_code;
		logic [RAM_BANK_W-1:0]  ram_bank_mask;
	} cfg_t;

	typedef struct packed {
		logic                 we;
		logic                 re;
		logic [RAM_IDX_W-1:0] idx;
		logic [DATA_W-1:0]    wdata;
	} ram_req_t;

	typedef struct packed {
		target_t               target;
		logic [ROM_ADDR_W-1:0] rom_addr;
		logic                  ram_hit;
	} decode_t;

endpackage

// File: rtl/core/rbm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_req_if - bus access channel
// Valid/ready channel carrying one CPU bus access per item.
// ----------------------------------------------------------------------------
interface rbm_req_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [rbm_pkg::ADDR_W-1:0] addr;
	logic [rbm_pkg::DATA_W-1:0] write_data;

	modport source (output valid, mode, addr, write_data, input ready);
	modport sink   (input valid, mode, addr, write_data, output ready);
endinterface

// File: rtl/core/rbm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_rsp_if - access result channel
// Valid/ready channel carrying one result item per bus access.
// ----------------------------------------------------------------------------
interface rbm_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     target;
	logic [rbm_pkg::ROM_ADDR_W-1:0] rom_addr;
	logic [rbm_pkg::DATA_W-1:0]     read_data;

	modport source (output valid, target, rom_addr, read_data, input ready);
	modport sink   (input valid, target, rom_addr, read_data, output ready);
endinterface

// File: rtl/core/rbm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_cfg_regs - configuration registers
// APB-style register file holding the ROM size code and the RAM bank mask.
// ----------------------------------------------------------------------------
module rbm_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rbm_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [rbm_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [rbm_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready,
	output rbm_pkg::cfg_t                      cfg
);

	rbm_pkg::cfg_t     cfg_q;
	rbm_pkg::reg_idx_t reg_idx;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = rbm_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				rbm_pkg::REG_ROM_SIZE: begin
					cfg_q.rom_size_code <= pwdata[rbm_pkg::SIZE_CODE_W-1:0];
				end
				rbm_pkg::REG_RAM_MASK: begin
					cfg_q.ram_bank_mask <= pwdata[rbm_pkg::RAM_BANK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			rbm_pkg::REG_ROM_SIZE: begin
				prdata[rbm_pkg::SIZE_CODE_W-1:0] = cfg_q.rom_size_code;
			end
			rbm_pkg::REG_RAM_MASK: begin
				prdata[rbm_pkg::RAM_BANK_W-1:0] = cfg_q.ram_bank_mask;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/core/rbm_bank_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_bank_ctrl - bank registers and access decode
// Holds the ROM bank, RAM bank and RAM enable, decodes each accepted access
// and issues the read or write to the cartridge RAM.
// ----------------------------------------------------------------------------
module rbm_bank_ctrl #(
	parameter int RAM_BANKS = rbm_pkg::RAM_BANKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rbm_pkg::cfg_t                  cfg,
	input  logic                           accept,
	input  logic                           mode,
	input  logic [rbm_pkg::ADDR_W-1:0]     addr,
	input  logic [rbm_pkg::DATA_W-1:0]     write_data,
	output rbm_pkg::ram_req_t              ram_req,
	output rbm_pkg::decode_t               dec
);

	localparam int CNT_W = 9;

	logic [rbm_pkg::ROM_BANK_W-1:0] rom_bank_q;
	logic [rbm_pkg::RAM_BANK_W-1:0] ram_bank_q;
	logic                           ram_enable_q;

	logic [CNT_W-1:0]               bank_cnt;
	logic [CNT_W-1:0]               bank_mask;
	logic [rbm_pkg::ROM_BANK_W-1:0] rom_bank_sel;
	logic                           banked;
	logic                           is_write;
	logic                           in_ram_area;
	logic                           ram_ok;

	assign is_write    = (rbm_pkg::mode_t'(mode) == rbm_pkg::MODE_WRITE);
	assign in_ram_area = (addr >= rbm_pkg::RAM_AREA_LO) && (addr <= rbm_pkg::RAM_AREA_HI);
	assign ram_ok      = ram_enable_q && (32'(ram_bank_q) < RAM_BANKS);

	// Bank count saturates at the largest supported ROM.
	always_comb begin
		bank_cnt = CNT_W'(2) << cfg.rom_size_code;
		if (bank_cnt > CNT_W'(rbm_pkg::ROM_BANKS_MAX)) begin
			bank_cnt = CNT_W'(rbm_pkg::ROM_BANKS_MAX);
		end
		bank_mask    = bank_cnt - CNT_W'(1);
		rom_bank_sel = write_data[rbm_pkg::ROM_BANK_W-1:0] &
		               bank_mask[rbm_pkg::ROM_BANK_W-1:0];
		if (rom_bank_sel == '0) begin
			rom_bank_sel = rbm_pkg::ROM_BANK_W'(1);
		end
	end

	assign banked = (bank_cnt > CNT_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q   <= rbm_pkg::ROM_BANK_W'(1);
			ram_bank_q   <= '0;
			ram_enable_q <= 1'b0;
		end else if (accept && is_write) begin
			priority if (addr <= rbm_pkg::RAM_EN_END) begin
				ram_enable_q <= (write_data[3:0] == rbm_pkg::RAM_EN_KEY);
			end else if (addr <= rbm_pkg::ROM_BANK_END) begin
				if (banked) begin
					rom_bank_q <= rom_bank_sel;
				end
			end else if (addr <= rbm_pkg::RAM_BANK_END) begin
				ram_bank_q <= write_data[rbm_pkg::RAM_BANK_W-1:0] & cfg.ram_bank_mask;
			end else begin
			end
		end
	end

	always_comb begin
		ram_req.we    = accept && is_write && in_ram_area && ram_ok;
		ram_req.re    = accept && !is_write && in_ram_area && ram_ok;
		ram_req.idx   = {ram_bank_q, addr[rbm_pkg::RAM_OFF_W-1:0]};
		ram_req.wdata = write_data;
	end

	always_comb begin
		dec.target   = rbm_pkg::TGT_NONE;
		dec.rom_addr = '0;
		dec.ram_hit  = 1'b0;
		if (!is_write) begin
			if (addr <= rbm_pkg::ROM_AREA_END) begin
				dec.target = rbm_pkg::TGT_ROM;
				if (banked && addr >= rbm_pkg::ROM_BANK1_LO) begin
					dec.rom_addr = {rom_bank_q, addr[rbm_pkg::ROM_OFF_W-1:0]};
				end else begin
					dec.rom_addr = rbm_pkg::ROM_ADDR_W'(addr);
				end
			end else if (in_ram_area) begin
				dec.target  = rbm_pkg::TGT_RAM;
				dec.ram_hit = ram_ok;
			end
		end
	end

	// The ROM bank register never holds bank zero.
	a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rom_bank_q != '0)
		else $error("ROM bank register holds zero");

	// The RAM is only written while it is enabled and the bank is mapped.
	a_write_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (ram_enable_q && (32'(ram_bank_q) < RAM_BANKS)))
		else $error("RAM write while disabled or unmapped");

	// A RAM read comes only from an accepted RAM-area read that hits.
	a_read_decode: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |-> (!ram_req.we && dec.ram_hit && dec.target == rbm_pkg::TGT_RAM))
		else $error("RAM read issued without a RAM hit");

endmodule

// File: rtl/core/rbm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_ram - cartridge RAM
// Single-port synchronous byte memory with a registered read.
// ----------------------------------------------------------------------------
module rbm_ram #(
	parameter int RAM_BANKS = rbm_pkg::RAM_BANKS_DEF
) (
	input  logic                        clk,
	input  rbm_pkg::ram_req_t           req,
	output logic [rbm_pkg::DATA_W-1:0]  rd_data
);

	localparam int DEPTH = RAM_BANKS * (2 ** rbm_pkg::RAM_OFF_W);
	localparam int AW    = $clog2(DEPTH);
	localparam int EXT_W = (AW > rbm_pkg::RAM_IDX_W) ? AW : rbm_pkg::RAM_IDX_W;

	logic [rbm_pkg::DATA_W-1:0] mem [DEPTH];
	logic [rbm_pkg::DATA_W-1:0] rd_q;
	logic [EXT_W-1:0]           idx_ext;
	logic [AW-1:0]              mem_addr;

	// Banks past RAM_BANKS never reach here, so the index stays in range.
	assign idx_ext  = EXT_W'(req.idx);
	assign mem_addr = idx_ext[AW-1:0];
	assign rd_data  = rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[mem_addr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_q <= mem[mem_addr];
		end
	end

endmodule

// File: rtl/core/rom_ram_bank_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper - cartridge ROM/RAM bank controller
// Decodes CPU bus accesses, keeps the bank registers and the cartridge RAM,
// and returns one result item per access.
// ----------------------------------------------------------------------------
//
//  Channel   Kind       Direction  Content
//  req       valid/rdy  in         mode, addr, write_data
//  rsp       valid/rdy  out        target, rom_addr, read_data
//  apb       APB write  in         rom_size_code (0x0), ram_bank_mask (0x4)
//
//  One item per cycle sustained while the result side is ready; an accepted
//  item is registered in stage 1 and then in the output register, which presents its result.
//  The first stage covers the RAM's registered read, the second is the
//  output register.
//  The RAM is not cleared at reset; bank registers and valids are.
//  A stalled output holds its result while one more item may enter stage 1.
//
module rom_ram_bank_mapper #(
	parameter int RAM_BANKS = rbm_pkg::RAM_BANKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rbm_req_if.sink                        req,
	rbm_rsp_if.source                      rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rbm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [rbm_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [rbm_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);

	rbm_pkg::cfg_t              cfg;
	rbm_pkg::ram_req_t          ram_req;
	rbm_pkg::decode_t           dec;
	logic [rbm_pkg::DATA_W-1:0] ram_rd;

	logic                           accept;
	logic                           adv_s1;
	logic                           valid_s1;
	rbm_pkg::decode_t               dec_s1;
	logic                           valid_s2;
	rbm_pkg::target_t               target_s2;
	logic [rbm_pkg::ROM_ADDR_W-1:0] rom_addr_s2;
	logic [rbm_pkg::DATA_W-1:0]     read_data_s2;
	logic [rbm_pkg::DATA_W-1:0]     read_data;

	rbm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbm_bank_ctrl #(.RAM_BANKS(RAM_BANKS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (accept),
		.mode       (req.mode),
		.addr       (req.addr),
		.write_data (req.write_data),
		.ram_req    (ram_req),
		.dec        (dec)
	);

	rbm_ram #(.RAM_BANKS(RAM_BANKS)) u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ram_rd)
	);

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || !valid_s2 || rsp.ready;
	assign accept    = req.valid && req.ready;

	// The RAM read register only loads on an accepted item, so it holds while
	// stage 1 is stalled.
	always_comb begin
		if (dec_s1.ram_hit) begin
			read_data = ram_rd;
		end else if (dec_s1.target == rbm_pkg::TGT_RAM) begin
			read_data = rbm_pkg::OPEN_BUS;
		end else begin
			read_data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec;
		end
		if (adv_s1) begin
			target_s2    <= dec_s1.target;
			rom_addr_s2  <= dec_s1.rom_addr;
			read_data_s2 <= read_data;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.target    = target_s2;
	assign rsp.rom_addr  = rom_addr_s2;
	assign rsp.read_data = read_data_s2;

endmodule

// File: tb/rbm_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbm_access_checker - result checker for the ROM/RAM bank mapper
// Watches the access and result channels and the register port, keeps its
// own copy of the bank registers and cartridge RAM, predicts the result of
// every accepted access and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module rbm_access_checker
	import rbm_pkg::*;
#(
	parameter int RAM_BANKS = RAM_BANKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rbm_req_if                    req,
	rbm_rsp_if                    rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int unsigned           errors,
	output int unsigned           results_due,
	output int unsigned           results_checked,
	output int unsigned           stored_reads,
	output int unsigned           banked_reads
);

	typedef struct packed {
		target_t               target;
		logic [ROM_ADDR_W-1:0] rom_addr;
		logic [DATA_W-1:0]     read_data;
	} access_result_t;

	localparam int RAM_BYTES = RAM_BANKS * (1 << RAM_OFF_W);

	logic [SIZE_CODE_W-1:0] size_code;
	logic [RAM_BANK_W-1:0]  bank_mask;
	logic [ROM_BANK_W-1:0]  rom_bank;
	logic [RAM_BANK_W-1:0]  ram_bank;
	logic                   ram_on;
	logic [DATA_W-1:0]      ram_image [RAM_BYTES];
	access_result_t         pending_results [$];

	function automatic int unsigned rom_bank_count();
		int unsigned n;
		n = 32'd2 << size_code;
		if (n > ROM_BANKS_MAX)
			n = ROM_BANKS_MAX;
		return n;
	endfunction

	// Applies one bus access to the mirrored state and returns its result.
	function automatic access_result_t map_access(mode_t m, logic [ADDR_W-1:0] a,
			logic [DATA_W-1:0] d);
		access_result_t r;
		int unsigned    n;
		int unsigned    idx;
		logic           mapped;
		r = '{target: TGT_NONE, rom_addr: '0, read_data: '0};
		n = rom_bank_count();
		idx = int'({ram_bank, a[RAM_OFF_W-1:0]});
		mapped = (ram_bank < RAM_BANKS) && (idx < RAM_BYTES);
		if (m == MODE_WRITE) begin
			if (a <= RAM_EN_END) begin
				ram_on = (d[3:0] == RAM_EN_KEY);
			end else if (a <= ROM_BANK_END) begin
				// With two banks or fewer the bank register is frozen.
				if (n > 2) begin
					rom_bank = d[ROM_BANK_W-1:0] & ROM_BANK_W'(n - 1);
					if (rom_bank == '0)
						rom_bank = 1;
				end
			end else if (a <= RAM_BANK_END) begin
				ram_bank = d[RAM_BANK_W-1:0] & bank_mask;
			end else if (a >= RAM_AREA_LO && a <= RAM_AREA_HI) begin
				if (ram_on && mapped)
					ram_image[idx] = d;
			end
		end else begin
			if (a <= ROM_AREA_END) begin
				r.target = TGT_ROM;
				if (n > 2 && a >= ROM_BANK1_LO) begin
					r.rom_addr = {rom_bank, a[ROM_OFF_W-1:0]};
					banked_reads++;
				end else begin
					r.rom_addr = ROM_ADDR_W'(a);
				end
			end else if (a >= RAM_AREA_LO && a <= RAM_AREA_HI) begin
				r.target = TGT_RAM;
				if (ram_on && mapped) begin
					r.read_data = ram_image[idx];
					stored_reads++;
				end else begin
					r.read_data = OPEN_BUS;
				end
			end
		end
		return r;
	endfunction

	task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
		errors++;
		$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		access_result_t want;
		if (!arst_n) begin
			size_code = '0;
			bank_mask = '0;
			rom_bank = 1;
			ram_bank = '0;
			ram_on = 1'b0;
			pending_results.delete();
			errors = 0;
			results_due = 0;
			results_checked = 0;
			stored_reads = 0;
			banked_reads = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_ROM_SIZE: size_code = pwdata[SIZE_CODE_W-1:0];
					REG_RAM_MASK: bank_mask = pwdata[RAM_BANK_W-1:0];
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result, target %0d rom_addr 0x%05h data 0x%02h",
						$time, rsp.target, rsp.rom_addr, rsp.read_data);
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (rsp.target !== want.target)
						report_field("target", 32'(want.target), 32'(rsp.target));
					if (rsp.rom_addr !== want.rom_addr)
						report_field("rom_addr", 32'(want.rom_addr), 32'(rsp.rom_addr));
					if (rsp.read_data !== want.read_data)
						report_field("read_data", 32'(want.read_data), 32'(rsp.read_data));
				end
			end
			if (req.valid && req.ready)
				pending_results.push_back(map_access(mode_t'(req.mode), req.addr,
					req.write_data));
			results_due = pending_results.size();
		end
	end

endmodule

// File: tb/tb_rom_ram_bank_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rom_ram_bank_mapper - testbench of the ROM/RAM bank mapper
// Drives directed and random bus accesses under a series of ROM size and
// RAM bank mask settings, with random gaps and back-pressure; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rom_ram_bank_mapper;
	import rbm_pkg::*;

	localparam int PHASES          = 8;
	localparam int PHASE_ACCESSES  = 110;
	localparam int PHASE_CODE [PHASES] = '{4, 1, 0, 7, 2, 3, 5, 4};
	localparam int PHASE_MASK [PHASES] = '{3, 1, 2, 3, 0, 2, 1, 3};

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned errors;
	int unsigned results_due;
	int unsigned results_checked;
	int unsigned stored_reads;
	int unsigned banked_reads;

	rbm_req_if req ();
	rbm_rsp_if rsp ();

	rom_ram_bank_mapper u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rbm_access_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.errors          (errors),
		.results_due     (results_due),
		.results_checked (results_checked),
		.stored_reads    (stored_reads),
		.banked_reads    (banked_reads)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Idle bursts on the access side and stalls on the result side.
	bit          src_gaps;
	bit          snk_gaps;
	int unsigned accesses_sent;

	// What the stimulus must know of the mapper to avoid reading RAM bytes
	// that were never written.
	logic                  cart_ram_on;
	logic [RAM_BANK_W-1:0] cart_ram_bank;
	logic [RAM_BANK_W-1:0] cart_bank_mask;
	bit                    ram_written [1 << RAM_IDX_W];
	logic [RAM_IDX_W-1:0]  filled_idx [$];

	task automatic send_access(mode_t m, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
		logic [RAM_IDX_W-1:0] idx;
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.mode       <= m;
		req.addr       <= a;
		req.write_data <= d;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		accesses_sent++;
		if (m == MODE_WRITE) begin
			if (a <= RAM_EN_END) begin
				cart_ram_on = (d[3:0] == RAM_EN_KEY);
			end else if (a >= ROM_BANK1_LO && a <= RAM_BANK_END) begin
				cart_ram_bank = d[RAM_BANK_W-1:0] & cart_bank_mask;
			end else if (a >= RAM_AREA_LO && a <= RAM_AREA_HI && cart_ram_on) begin
				idx = {cart_ram_bank, a[RAM_OFF_W-1:0]};
				if (!ram_written[idx]) begin
					ram_written[idx] = 1'b1;
					filled_idx.push_back(idx);
				end
			end
		end
	endtask

	// Lowers valid, then waits until every result is back and the pipeline is empty.
	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t r, logic [CFG_DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (r == REG_RAM_MASK)
			cart_bank_mask = v[RAM_BANK_W-1:0];
	endtask

	task automatic random_access();
		int unsigned          pick;
		int unsigned          start;
		int unsigned          k;
		logic [ADDR_W-1:0]    a;
		logic [DATA_W-1:0]    d;
		logic [RAM_IDX_W-1:0] idx;
		bit                   found;
		pick = $urandom_range(0, 99);
		d = DATA_W'($urandom_range(0, 255));
		a = ADDR_W'($urandom_range(RAM_AREA_LO, RAM_AREA_HI));
		// Keep RAM switched on most of the time so data paths are exercised.
		if (!cart_ram_on && $urandom_range(0, 2) == 0) begin
			d[3:0] = RAM_EN_KEY;
			send_access(MODE_WRITE, ADDR_W'($urandom_range(0, RAM_EN_END)), d);
		end else if (pick < 20) begin
			a = ADDR_W'($urandom_range(0, ROM_AREA_END));
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: a = '0;
					1: a = ROM_BANK_END;
					2: a = ROM_BANK1_LO;
					default: a = ROM_AREA_END;
				endcase
			end
			send_access(MODE_READ, a, d);
		end else if (pick < 25) begin
			if ($urandom_range(0, 3) != 0)
				d[3:0] = RAM_EN_KEY;
			send_access(MODE_WRITE, ADDR_W'($urandom_range(0, RAM_EN_END)), d);
		end else if (pick < 33) begin
			send_access(MODE_WRITE,
				ADDR_W'($urandom_range(RAM_EN_END + 1, ROM_BANK_END)), d);
		end else if (pick < 39) begin
			send_access(MODE_WRITE,
				ADDR_W'($urandom_range(ROM_BANK1_LO, RAM_BANK_END)), d);
		end else if (pick < 57) begin
			send_access(MODE_WRITE, a, d);
		end else if (pick < 62) begin
			// Read straight after the write to the same byte.
			send_access(MODE_WRITE, a, d);
			send_access(MODE_READ, a, DATA_W'($urandom_range(0, 255)));
		end else if (pick < 85) begin
			found = 1'b0;
			if (cart_ram_on && filled_idx.size() > 0) begin
				start = $urandom_range(0, filled_idx.size() - 1);
				for (k = 0; k < filled_idx.size() && !found; k++) begin
					idx = filled_idx[(start + k) % filled_idx.size()];
					if (idx[RAM_IDX_W-1:RAM_OFF_W] == cart_ram_bank) begin
						found = 1'b1;
						a = RAM_AREA_LO | ADDR_W'(idx[RAM_OFF_W-1:0]);
					end
				end
			end
			if (cart_ram_on && !found)
				send_access(MODE_WRITE, a, d);
			else
				send_access(MODE_READ, a, d);
		end else if (pick < 93) begin
			if ($urandom_range(0, 1) == 0)
				a = ADDR_W'($urandom_range(ROM_AREA_END + 1, RAM_AREA_LO - 1));
			else
				a = ADDR_W'($urandom_range(RAM_AREA_HI + 1, 16'hFFFF));
			send_access(MODE_READ, a, d);
		end else begin
			case ($urandom_range(0, 2))
				0: a = ADDR_W'($urandom_range(RAM_BANK_END + 1, ROM_AREA_END));
				1: a = ADDR_W'($urandom_range(ROM_AREA_END + 1, RAM_AREA_LO - 1));
				default: a = ADDR_W'($urandom_range(RAM_AREA_HI + 1, 16'hFFFF));
			endcase
			send_access(MODE_WRITE, a, d);
		end
	endtask

	initial begin
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (snk_gaps && $urandom_range(0, 9) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	initial begin
		int unsigned p;
		int unsigned i;
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		req.valid      <= 1'b0;
		req.mode       <= MODE_READ;
		req.addr       <= '0;
		req.write_data <= '0;
		src_gaps = 1'b1;
		snk_gaps = 1'b1;
		accesses_sent = 0;
		cart_ram_on = 1'b0;
		cart_ram_bank = '0;
		cart_bank_mask = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: two ROM banks, so the bank register is frozen.
		send_access(MODE_READ,  16'h0000, 8'h00);
		send_access(MODE_READ,  16'h7FFF, 8'hFF);
		send_access(MODE_WRITE, 16'h2000, 8'h05);
		send_access(MODE_READ,  16'h4000, 8'h00);
		send_access(MODE_READ,  16'hA000, 8'h00);
		send_access(MODE_READ,  16'h8000, 8'h00);
		send_access(MODE_READ,  16'h9FFF, 8'h00);
		send_access(MODE_READ,  16'hC000, 8'h00);
		send_access(MODE_READ,  16'hFFFF, 8'h00);
		send_access(MODE_WRITE, 16'h6000, 8'h12);
		send_access(MODE_WRITE, 16'hC000, 8'h34);
		send_access(MODE_WRITE, 16'hFFFF, 8'hFF);
		send_access(MODE_WRITE, 16'h0000, 8'h0A);
		send_access(MODE_WRITE, 16'hA000, 8'h00);
		send_access(MODE_WRITE, 16'hBFFF, 8'hFF);
		send_access(MODE_READ,  16'hA000, 8'h00);
		send_access(MODE_READ,  16'hBFFF, 8'h00);
		send_access(MODE_WRITE, 16'h5FFF, 8'hFF);
		send_access(MODE_READ,  16'hBFFF, 8'h00);
		send_access(MODE_WRITE, 16'h1FFF, 8'hFB);
		send_access(MODE_READ,  16'hA000, 8'h00);
		send_access(MODE_WRITE, 16'h1000, 8'h5A);

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			reg_write(REG_ROM_SIZE, CFG_DATA_W'(PHASE_CODE[p]));
			reg_write(REG_RAM_MASK, CFG_DATA_W'(PHASE_MASK[p]));
			if (p == 0) begin
				// Bank zero maps to one, full mask, top ROM bank, top RAM bank.
				send_access(MODE_WRITE, 16'h2000, 8'h00);
				send_access(MODE_READ,  16'h4000, 8'h00);
				send_access(MODE_WRITE, 16'h3FFF, 8'hFF);
				send_access(MODE_READ,  16'h7FFF, 8'h00);
				send_access(MODE_READ,  16'h3FFF, 8'h00);
				send_access(MODE_WRITE, 16'h4000, 8'h03);
				send_access(MODE_WRITE, 16'hB123, 8'hC3);
				send_access(MODE_READ,  16'hB123, 8'h00);
			end
			for (i = 0; i < PHASE_ACCESSES; i++) begin
				if (i % 40 == 0) begin
					src_gaps = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
					snk_gaps = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
				end
				random_access();
			end
		end
		wait_drained();

		$display("Sent %0d bus accesses under %0d register settings, ROM sizes from two banks",
			accesses_sent, PHASES + 1);
		$display("to saturated; %0d results checked, %0d stored RAM reads, %0d banked ROM reads.",
			results_checked, stored_reads, banked_reads);
		if (errors == 0 && results_due == 0) begin
			$display("rom_ram_bank_mapper: match");
		end else begin
			$display("rom_ram_bank_mapper: mismatch");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Run timed out with %0d results outstanding.", results_due);
		$display("rom_ram_bank_mapper: mismatch");
		$finish;
	end

endmodule
